// File: hdl/pcc_pkg.sv
// shared types, constants and arctangent table for the polar/cartesian converter
package pcc_pkg;

    // field widths of the transaction payloads and length of the arctangent table
    localparam int FIELD_W  = 16;
    localparam int RADIUS_W = 17;
    localparam int ANGLE_W  = 32;
    localparam int TAB_LEN  = 24;

    // operation codes
    localparam logic OP_TO_POLAR = 1'b0;
    localparam logic OP_TO_CART  = 1'b1;

    // angle constants, full turn is 2^32
    localparam logic [ANGLE_W-1:0] ANGLE_PI      = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] ANGLE_HALF_PI = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] ANGLE_ROUND   = 32'h0000_8000;

    // reciprocal of the limiting cordic gain in q24
    localparam logic [23:0] GAIN_Q24 = 24'd10188014;

    typedef struct packed {
        logic                      op;
        logic signed [FIELD_W-1:0] first_value;
        logic signed [FIELD_W-1:0] second_value;
    } t_in_item;

    typedef struct packed {
        logic signed [RADIUS_W-1:0] first_result;
        logic signed [FIELD_W-1:0]  second_result;
    } t_out_item;

    // control that travels alongside the datapath
    typedef struct packed {
        logic valid;
        logic op;
        logic zero;
    } t_ctl;

    // arctangent of 2^-idx as a fraction of a full turn
    function automatic logic [ANGLE_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/polar_cartesian_converter_top.sv
// top level of the cordic polar/cartesian converter
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------
//  input     | start, busy          | i_item (op, first/second value)
//  result    | o_valid strobe       | o_item (first/second result)
//
// one transaction accepted every cycle; busy is held low
// pipeline registers: input pre-rotation, one cell per iteration (ITERATIONS
// clamped to 1..24), gain multiply, round/saturate, result register
// reset clears the control bits (valid, op, zero) of the chain only
// the result strobe lasts one cycle and the receiver cannot stall it
module polar_cartesian_converter_top #(
    parameter int ITERATIONS = 16,
    parameter int DATA_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pcc_pkg::t_in_item   i_item,
    output logic                o_valid,
    output pcc_pkg::t_out_item  o_item
);

    localparam int STEPS = (ITERATIONS > pcc_pkg::TAB_LEN) ? pcc_pkg::TAB_LEN :
                           ((ITERATIONS < 1) ? 1 : ITERATIONS);
    localparam int FRAC  = (DATA_WIDTH < 8) ? 8 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
    localparam int XW    = pcc_pkg::FIELD_W + FRAC + 3;
    localparam int LAT   = STEPS + 4;
    localparam int AW    = pcc_pkg::ANGLE_W;

    logic signed [XW-1:0] a_ext, b_ext;
    logic signed [XW-1:0] a_scl, b_scl;
    logic [AW-1:0]        z_rot;
    logic [AW-1:0]        z_chk;

    logic signed [XW-1:0] r_pre_x, n_pre_x;
    logic signed [XW-1:0] r_pre_y, n_pre_y;
    logic [AW-1:0]        r_pre_z, n_pre_z;
    pcc_pkg::t_ctl        r_pre_ctl, n_pre_ctl;

    logic signed [XW-1:0] w_x [0:STEPS];
    logic signed [XW-1:0] w_y [0:STEPS];
    logic [AW-1:0]        w_z [0:STEPS];
    pcc_pkg::t_ctl        w_ctl [0:STEPS];

    pcc_pkg::t_ctl        r_g1_ctl, r_g2_ctl;
    logic [AW-1:0]        r_g1_z, r_g2_z;
    logic signed [pcc_pkg::RADIUS_W-1:0] g_x;
    logic signed [pcc_pkg::FIELD_W-1:0]  g_y;
    logic [AW-1:0]        z_rnd;

    logic                 r_valid;
    pcc_pkg::t_out_item   r_out, n_out;

    assign busy = 1'b0;

    // input scaling and quadrant pre-rotation
    always_comb begin
        a_ext = XW'(i_item.first_value);
        b_ext = XW'(i_item.second_value);
        a_scl = a_ext <<< FRAC;
        b_scl = b_ext <<< FRAC;
        z_rot = {i_item.second_value, 16'h0000};
        z_chk = z_rot + pcc_pkg::ANGLE_HALF_PI;
        n_pre_ctl.valid = start && !busy;
        n_pre_ctl.op    = i_item.op;
        n_pre_ctl.zero  = (i_item.first_value == '0) && (i_item.second_value == '0);
        if (i_item.op == pcc_pkg::OP_TO_POLAR) begin
            if (a_ext[XW-1]) begin
                n_pre_x = -a_scl;
                n_pre_y = -b_scl;
                n_pre_z = pcc_pkg::ANGLE_PI;
            end else begin
                n_pre_x = a_scl;
                n_pre_y = b_scl;
                n_pre_z = '0;
            end
        end else begin
            n_pre_y = '0;
            if (z_chk[AW-1]) begin
                n_pre_x = a_ext[XW-1] ? '0 : -a_scl;
                n_pre_z = z_rot + pcc_pkg::ANGLE_PI;
            end else begin
                n_pre_x = a_ext[XW-1] ? '0 : a_scl;
                n_pre_z = z_rot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ctl <= '0;
        end else begin
            r_pre_ctl <= n_pre_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pre_x <= n_pre_x;
        r_pre_y <= n_pre_y;
        r_pre_z <= n_pre_z;
    end

    // chain of micro-rotation cells
    assign w_x[0]   = r_pre_x;
    assign w_y[0]   = r_pre_y;
    assign w_z[0]   = r_pre_z;
    assign w_ctl[0] = r_pre_ctl;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        pcc_cell #(
            .XW   (XW),
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_ctl   (w_ctl[g]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_ctl   (w_ctl[g+1])
        );
    end

    // gain correction of both coordinates
    pcc_gain #(
        .XW    (XW),
        .FRAC  (FRAC),
        .OUT_W (pcc_pkg::RADIUS_W)
    ) u_gain_x (
        .i_clk (i_clk),
        .i_v   (w_x[STEPS]),
        .o_v   (g_x)
    );

    pcc_gain #(
        .XW    (XW),
        .FRAC  (FRAC),
        .OUT_W (pcc_pkg::FIELD_W)
    ) u_gain_y (
        .i_clk (i_clk),
        .i_v   (w_y[STEPS]),
        .o_v   (g_y)
    );

    // control and angle alongside the gain stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g1_ctl <= '0;
            r_g2_ctl <= '0;
        end else begin
            r_g1_ctl <= w_ctl[STEPS];
            r_g2_ctl <= r_g1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_g1_z <= w_z[STEPS];
        r_g2_z <= r_g1_z;
    end

    // result selection and angle rounding
    always_comb begin
        z_rnd = r_g2_z + pcc_pkg::ANGLE_ROUND;
        n_out.first_result = g_x;
        if (r_g2_ctl.op == pcc_pkg::OP_TO_POLAR) begin
            if (r_g2_ctl.zero) begin
                n_out.first_result  = '0;
                n_out.second_result = '0;
            end else begin
                n_out.second_result = z_rnd[AW-1:AW-pcc_pkg::FIELD_W];
            end
        end else begin
            n_out.second_result = g_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_g2_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;

    // every result strobe has a transaction started the pipeline depth earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result strobe without matching transaction");

    // vectoring starts from the right half plane
    a_right_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pre_ctl.valid && (r_pre_ctl.op == pcc_pkg::OP_TO_POLAR)) |-> !r_pre_x[XW-1])
        else $error("vectoring start vector in left half plane");

    // rotation starts from an angle within a quarter turn of zero
    a_quarter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pre_ctl.valid && (r_pre_ctl.op == pcc_pkg::OP_TO_CART))
            |-> ((r_pre_z + pcc_pkg::ANGLE_HALF_PI) < pcc_pkg::ANGLE_PI))
        else $error("rotation start angle beyond a quarter turn");

    // rotation starts with no y component
    a_y_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pre_ctl.valid && (r_pre_ctl.op == pcc_pkg::OP_TO_CART)) |-> (r_pre_y == '0))
        else $error("rotation start vector has y component");

endmodule

// File: hdl/pcc_cell.sv
// one cordic micro-rotation cell of the conversion chain
module pcc_cell #(
    parameter int XW   = 35,
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    input  logic [pcc_pkg::ANGLE_W-1:0]   i_z,
    input  pcc_pkg::t_ctl                 i_ctl,
    output logic signed [XW-1:0]          o_x,
    output logic signed [XW-1:0]          o_y,
    output logic [pcc_pkg::ANGLE_W-1:0]   o_z,
    output pcc_pkg::t_ctl                 o_ctl
);

    localparam logic [pcc_pkg::ANGLE_W-1:0] ATAN = pcc_pkg::atan_entry(5'(STEP));

    logic signed [XW-1:0]        r_x, n_x;
    logic signed [XW-1:0]        r_y, n_y;
    logic [pcc_pkg::ANGLE_W-1:0] r_z, n_z;
    pcc_pkg::t_ctl               r_ctl;
    logic signed [XW-1:0]        dx;
    logic signed [XW-1:0]        dy;

    // flooring shifts of the neighbour coordinate
    assign dx = i_y >>> STEP;
    assign dy = i_x >>> STEP;

    // direction: drive y to zero when vectoring, z to zero when rotating
    always_comb begin
        if (i_ctl.op == pcc_pkg::OP_TO_POLAR) begin
            if (!i_y[XW-1]) begin
                n_x = i_x + dx;
                n_y = i_y - dy;
                n_z = i_z + ATAN;
            end else begin
                n_x = i_x - dx;
                n_y = i_y + dy;
                n_z = i_z - ATAN;
            end
        end else begin
            if (!i_z[pcc_pkg::ANGLE_W-1]) begin
                n_x = i_x - dx;
                n_y = i_y + dy;
                n_z = i_z - ATAN;
            end else begin
                n_x = i_x + dx;
                n_y = i_y - dy;
                n_z = i_z + ATAN;
            end
        end
    end

    // control register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;
    assign o_ctl = r_ctl;

endmodule

// File: hdl/pcc_gain.sv
// gain correction: floor to q8, multiply by q24 gain, round and saturate
module pcc_gain #(
    parameter int XW    = 35,
    parameter int FRAC  = 16,
    parameter int OUT_W = 17
) (
    input  logic                    i_clk,
    input  logic signed [XW-1:0]    i_v,
    output logic signed [OUT_W-1:0] o_v
);

    localparam int Q8W = XW - (FRAC - 8);
    localparam int PW  = Q8W + 25;
    localparam int RW  = PW - 32;
    localparam logic signed [RW-1:0] SAT_MAX = RW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam logic signed [RW-1:0] SAT_MIN = RW'(-(64'sd1 <<< (OUT_W - 1)));
    localparam logic signed [PW-1:0] HALF    = PW'(64'sd1 <<< 31);

    logic signed [Q8W-1:0]   q8;
    logic signed [24:0]      gain_s;
    logic signed [PW-1:0]    r_prod, n_prod;
    logic signed [PW-1:0]    rnd;
    logic signed [RW-1:0]    rounded;
    logic signed [OUT_W-1:0] r_out, n_out;

    // floor to eight fraction bits and multiply
    assign q8     = i_v[XW-1:FRAC-8];
    assign gain_s = $signed({1'b0, pcc_pkg::GAIN_Q24});
    assign n_prod = PW'(q8) * PW'(gain_s);

    // round half up and saturate
    always_comb begin
        rnd     = r_prod + HALF;
        rounded = rnd[PW-1:32];
        if (rounded > SAT_MAX) begin
            n_out = SAT_MAX[OUT_W-1:0];
        end else if (rounded < SAT_MIN) begin
            n_out = SAT_MIN[OUT_W-1:0];
        end else begin
            n_out = rounded[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    assign o_v = r_out;

endmodule
